[rtl/xmbr_pkg.sv]
// package: codes, types and constants for the xymodem block receiver
package xmbr_pkg;

    localparam int LONG_BLOCK    = 1024;
    localparam int SHORT_BLOCK   = 128;
    localparam int START_RETRIES = 30;
    localparam int BLOCK_RETRIES = 10;

    localparam logic [7:0] B_SOH = 8'h01;
    localparam logic [7:0] B_STX = 8'h02;
    localparam logic [7:0] B_EOT = 8'h04;
    localparam logic [7:0] B_ACK = 8'h06;
    localparam logic [7:0] B_NAK = 8'h15;
    localparam logic [7:0] B_CAN = 8'h18;
    localparam logic [7:0] B_C   = 8'h43;

    localparam logic [26:0] SIZE_MAX_BYTES = 27'd67108864;

    localparam logic [1:0] ACT_BYTE    = 2'd0;
    localparam logic [1:0] ACT_TIMEOUT = 2'd1;
    localparam logic [1:0] ACT_START   = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_SEND    = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] V_GOOD      = 3'd0;
    localparam logic [2:0] V_DUP       = 3'd1;
    localparam logic [2:0] V_HEADER    = 3'd2;
    localparam logic [2:0] V_EOF       = 3'd3;
    localparam logic [2:0] V_CANCEL    = 3'd4;
    localparam logic [2:0] V_ERROR     = 3'd5;
    localparam logic [2:0] V_EXHAUSTED = 3'd6;

    localparam logic [2:0] CFG_CRC   = 3'd0;
    localparam logic [2:0] CFG_YMOD  = 3'd1;
    localparam logic [2:0] CFG_LIMIT = 3'd2;

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_WAIT = 7'b0000010,
        PH_SEQ  = 7'b0000100,
        PH_CMPL = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_THI  = 7'b0100000,
        PH_TLO  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       keep;
        logic [9:0] offset;
        logic [2:0] verdict;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_result_set;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

[rtl/xmbr_out_queue.sv]
// output queue: holds up to three results of one transaction and delivers them one by one
module xmbr_out_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  xmbr_pkg::t_result_set i_set,
    output logic                 o_can_load,
    output logic                 o_valid,
    input  logic                 i_ready,
    output xmbr_pkg::t_result    o_res,
    output logic                 o_last
);
    logic [1:0]        r_cnt;
    logic [1:0]        r_idx;
    xmbr_pkg::t_result r_q [3];
    logic              w_pop;

    assign o_valid = (r_cnt != 2'd0);
    assign w_pop = o_valid && i_ready;
    assign o_can_load = !o_valid || (w_pop && r_cnt == 2'd1);
    assign o_res = r_q[r_idx];
    assign o_last = (r_cnt == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_idx <= 2'd0;
        end else if (i_load && o_can_load) begin
            r_cnt <= i_set.count;
            r_idx <= 2'd0;
        end else if (w_pop) begin
            r_cnt <= r_cnt - 2'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_q[0] <= i_set.r0;
            r_q[1] <= i_set.r1;
            r_q[2] <= i_set.r2;
        end
    end
endmodule

[rtl/xymodem_block_receiver_top.sv]
// top level: xymodem block receiver with crc-16 or sum trailer check
//  channel | signals                                      | dir
//  input   | i_valid/o_ready, i_action, i_rx_byte          | in
//  output  | o_valid/i_ready, o_out_kind .. o_last        | out
//  config  | i_cfg_we, i_cfg_index, i_cfg_data             | in
// one transaction per cycle while o_ready is high; its results (zero to three) are delivered
// one per cycle from the output queue while i_ready is high, so rate is set by results per item on the output side
// synchronous active-low reset puts the receiver in idle, registers at defaults
// input stalls only while the output queue still holds undelivered results
module xymodem_block_receiver_top #(
    parameter int LONG_BLOCK    = xmbr_pkg::LONG_BLOCK,
    parameter int START_RETRIES = xmbr_pkg::START_RETRIES,
    parameter int BLOCK_RETRIES = xmbr_pkg::BLOCK_RETRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_keep,
    output logic [9:0]  o_byte_offset,
    output logic [2:0]  o_verdict,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [26:0] i_cfg_data
);
    localparam logic [10:0] LONG_LEN  = 11'(LONG_BLOCK);
    localparam logic [10:0] SHORT_LEN = 11'(xmbr_pkg::SHORT_BLOCK);
    localparam logic [4:0]  START_R   = 5'(START_RETRIES);
    localparam logic [4:0]  BLOCK_R   = 5'(BLOCK_RETRIES);

    logic        r_crc_mode, n_crc_mode;
    logic        r_ymodem, n_ymodem;
    logic [26:0] r_limit, n_limit;
    xmbr_pkg::t_phase r_phase, n_phase;
    logic [10:0] r_blen, n_blen;
    logic [10:0] r_left, n_left;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_cmpl, n_cmpl;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_thi, n_thi;
    logic [7:0]  r_expect, n_expect;
    logic        r_await, n_await;
    logic [7:0]  r_sync, n_sync;
    logic [4:0]  r_retries, n_retries;
    logic [26:0] r_rcvd, n_rcvd;

    xmbr_pkg::t_result_set w_set;
    xmbr_pkg::t_result     w_res;
    logic w_can_load, w_go;

    assign o_ready = w_can_load;
    assign w_go = i_valid && w_can_load;

    function automatic xmbr_pkg::t_result mk(input logic [1:0] k, input logic [7:0] d,
                                             input logic [2:0] v);
        xmbr_pkg::t_result r;
        r.kind = k;
        r.data = d;
        r.keep = 1'b0;
        r.offset = 10'd0;
        r.verdict = v;
        return r;
    endfunction

    always_comb begin
        logic        ok;
        logic [15:0] tw;
        logic [26:0] lim;
        logic [26:0] room;
        logic [10:0] off;
        logic [27:0] pos;
        n_crc_mode = r_crc_mode;
        n_ymodem = r_ymodem;
        n_limit = r_limit;
        n_phase = r_phase;
        n_blen = r_blen;
        n_left = r_left;
        n_seq = r_seq;
        n_cmpl = r_cmpl;
        n_crc = r_crc;
        n_sum = r_sum;
        n_thi = r_thi;
        n_expect = r_expect;
        n_await = r_await;
        n_sync = r_sync;
        n_retries = r_retries;
        n_rcvd = r_rcvd;
        w_set = '0;
        ok = 1'b0;
        tw = {r_thi, i_rx_byte};
        lim = r_await ? xmbr_pkg::SIZE_MAX_BYTES : r_limit;
        room = r_limit - r_rcvd;
        off = r_blen - r_left;
        pos = {1'b0, r_rcvd} + {17'd0, off};
        if (i_cfg_we) begin
            case (i_cfg_index)
                xmbr_pkg::CFG_CRC[1:0]:   n_crc_mode = i_cfg_data[0];
                xmbr_pkg::CFG_YMOD[1:0]:  n_ymodem = i_cfg_data[0];
                xmbr_pkg::CFG_LIMIT[1:0]: n_limit = i_cfg_data;
                default: ;
            endcase
        end
        if (w_go) begin
            if (i_action == xmbr_pkg::ACT_START) begin
                n_expect = r_ymodem ? 8'd0 : 8'd1;
                n_await = r_ymodem;
                n_sync = r_crc_mode ? xmbr_pkg::B_C : xmbr_pkg::B_NAK;
                n_retries = START_R;
                n_rcvd = '0;
                n_phase = xmbr_pkg::PH_WAIT;
                w_set.count = 2'd1;
                w_set.r0 = mk(xmbr_pkg::KIND_SEND, n_sync, 3'd0);
            end else if (i_action == xmbr_pkg::ACT_TIMEOUT) begin
                if (r_phase != xmbr_pkg::PH_IDLE) begin
                    if (r_retries <= 5'd1) begin
                        n_retries = '0;
                        n_phase = xmbr_pkg::PH_IDLE;
                        w_set.count = 2'd3;
                        w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_CAN, 3'd0);
                        w_set.r1 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_CAN, 3'd0);
                        w_set.r2 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_EXHAUSTED);
                    end else begin
                        n_retries = r_retries - 5'd1;
                        n_phase = xmbr_pkg::PH_WAIT;
                        w_set.count = 2'd1;
                        w_set.r0 = mk(xmbr_pkg::KIND_SEND, r_sync, 3'd0);
                    end
                end
            end else if (i_action == xmbr_pkg::ACT_BYTE) begin
                unique case (r_phase)
                    xmbr_pkg::PH_WAIT: begin
                        if (i_rx_byte == xmbr_pkg::B_STX || i_rx_byte == xmbr_pkg::B_SOH) begin
                            n_blen = (i_rx_byte == xmbr_pkg::B_STX) ? LONG_LEN : SHORT_LEN;
                            n_phase = xmbr_pkg::PH_SEQ;
                        end else if (i_rx_byte == xmbr_pkg::B_CAN) begin
                            n_phase = xmbr_pkg::PH_IDLE;
                            w_set.count = 2'd1;
                            w_set.r0 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_CANCEL);
                        end else if (i_rx_byte == xmbr_pkg::B_EOT) begin
                            n_expect = r_ymodem ? 8'd0 : 8'd1;
                            n_await = r_ymodem;
                            n_sync = r_crc_mode ? xmbr_pkg::B_C : xmbr_pkg::B_NAK;
                            w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_ACK, 3'd0);
                            if (r_ymodem) begin
                                w_set.count = 2'd3;
                                w_set.r1 = mk(xmbr_pkg::KIND_SEND, n_sync, 3'd0);
                                w_set.r2 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_EOF);
                            end else begin
                                n_phase = xmbr_pkg::PH_IDLE;
                                w_set.count = 2'd2;
                                w_set.r1 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_EOF);
                            end
                        end
                    end
                    xmbr_pkg::PH_SEQ: begin
                        n_seq = i_rx_byte;
                        n_phase = xmbr_pkg::PH_CMPL;
                    end
                    xmbr_pkg::PH_CMPL: begin
                        n_cmpl = i_rx_byte;
                        n_left = r_blen;
                        n_crc = '0;
                        n_sum = '0;
                        n_thi = '0;
                        n_phase = xmbr_pkg::PH_DATA;
                    end
                    xmbr_pkg::PH_DATA: begin
                        w_set.count = 2'd1;
                        w_set.r0 = mk(xmbr_pkg::KIND_PAYLOAD, i_rx_byte, 3'd0);
                        w_set.r0.keep = (pos < {1'b0, lim});
                        w_set.r0.offset = off[9:0];
                        n_crc = xmbr_pkg::crc_update(r_crc, i_rx_byte);
                        n_sum = r_sum + i_rx_byte;
                        n_left = r_left - 11'd1;
                        if (r_left == 11'd1) begin
                            n_phase = r_crc_mode ? xmbr_pkg::PH_THI : xmbr_pkg::PH_TLO;
                        end
                    end
                    xmbr_pkg::PH_THI: begin
                        n_thi = i_rx_byte;
                        n_phase = xmbr_pkg::PH_TLO;
                    end
                    xmbr_pkg::PH_TLO: begin
                        ok = r_crc_mode ? (tw == r_crc) : (i_rx_byte == r_sum);
                        n_phase = xmbr_pkg::PH_WAIT;
                        if (r_seq != ~r_cmpl || !ok
                            || (r_seq != (r_expect - 8'd1) && r_seq != r_expect
                                && !(r_await && r_seq == 8'd1))) begin
                            n_phase = xmbr_pkg::PH_IDLE;
                            w_set.count = 2'd3;
                            w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_CAN, 3'd0);
                            w_set.r1 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_CAN, 3'd0);
                            w_set.r2 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_ERROR);
                        end else if (r_seq == (r_expect - 8'd1)) begin
                            n_sync = xmbr_pkg::B_ACK;
                            w_set.count = 2'd2;
                            w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_ACK, 3'd0);
                            w_set.r1 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_DUP);
                        end else if (r_seq != r_expect) begin
                            // fallback to xmodem: block 1 while header expected
                            n_expect = 8'd2;
                            n_await = 1'b0;
                            n_ymodem = 1'b0;
                            n_limit = xmbr_pkg::SIZE_MAX_BYTES;
                            n_retries = BLOCK_R;
                            n_sync = xmbr_pkg::B_ACK;
                            n_rcvd = (r_rcvd < xmbr_pkg::SIZE_MAX_BYTES)
                                ? ((({16'd0, r_blen} < xmbr_pkg::SIZE_MAX_BYTES - r_rcvd)
                                    ? r_rcvd + {16'd0, r_blen} : xmbr_pkg::SIZE_MAX_BYTES))
                                : r_rcvd;
                            w_set.count = 2'd2;
                            w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_ACK, 3'd0);
                            w_set.r1 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_GOOD);
                        end else if (r_await) begin
                            n_await = 1'b0;
                            n_expect = 8'd1;
                            n_rcvd = '0;
                            w_set.count = 2'd3;
                            w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_ACK, 3'd0);
                            w_set.r1 = mk(xmbr_pkg::KIND_SEND, r_sync, 3'd0);
                            w_set.r2 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_HEADER);
                        end else begin
                            n_retries = BLOCK_R;
                            n_sync = xmbr_pkg::B_ACK;
                            if (r_rcvd < r_limit) begin
                                n_rcvd = ({16'd0, r_blen} < room)
                                    ? r_rcvd + {16'd0, r_blen} : r_limit;
                            end
                            n_expect = r_expect + 8'd1;
                            w_set.count = 2'd2;
                            w_set.r0 = mk(xmbr_pkg::KIND_SEND, xmbr_pkg::B_ACK, 3'd0);
                            w_set.r1 = mk(xmbr_pkg::KIND_VERDICT, 8'd0, xmbr_pkg::V_GOOD);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_mode <= 1'b1;
            r_ymodem <= 1'b0;
            r_limit <= xmbr_pkg::SIZE_MAX_BYTES;
            r_phase <= xmbr_pkg::PH_IDLE;
            r_blen <= '0;
            r_left <= '0;
            r_seq <= '0;
            r_cmpl <= '0;
            r_crc <= '0;
            r_sum <= '0;
            r_thi <= '0;
            r_expect <= '0;
            r_await <= 1'b0;
            r_sync <= xmbr_pkg::B_C;
            r_retries <= START_R;
            r_rcvd <= '0;
        end else begin
            r_crc_mode <= n_crc_mode;
            r_ymodem <= n_ymodem;
            r_limit <= n_limit;
            r_phase <= n_phase;
            r_blen <= n_blen;
            r_left <= n_left;
            r_seq <= n_seq;
            r_cmpl <= n_cmpl;
            r_crc <= n_crc;
            r_sum <= n_sum;
            r_thi <= n_thi;
            r_expect <= n_expect;
            r_await <= n_await;
            r_sync <= n_sync;
            r_retries <= n_retries;
            r_rcvd <= n_rcvd;
        end
    end

    xmbr_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_go),
        .i_set      (w_set),
        .o_can_load (w_can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_res      (w_res),
        .o_last     (o_last)
    );

    assign o_out_kind = w_res.kind;
    assign o_out_byte = w_res.data;
    assign o_keep = w_res.keep;
    assign o_byte_offset = w_res.offset;
    assign o_verdict = w_res.verdict;
endmodule

[rtl/xmbr_checker.sv]
// checker: port-level properties of the xymodem block receiver
module xmbr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [1:0] o_out_kind,
    input logic [7:0] o_out_byte,
    input logic       o_keep,
    input logic [2:0] o_verdict,
    input logic       o_last
);
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte))
        else $error("output dropped while stalled");
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_ready)
        else $error("ready while results remain");
    a_keep_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_keep |-> o_out_kind == xmbr_pkg::KIND_PAYLOAD)
        else $error("keep on non-payload");
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == xmbr_pkg::KIND_VERDICT |-> o_last && o_out_byte == 8'd0)
        else $error("verdict not last");
    a_payload_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_kind == xmbr_pkg::KIND_PAYLOAD |-> o_last && o_verdict == 3'd0)
        else $error("payload not alone");
endmodule

bind xymodem_block_receiver_top xmbr_checker u_checker (.*);
